// ===== design/dsst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsst_pkg
// Shared types, constants and helpers for the deployment signal state tracker.
// ----------------------------------------------------------------------------
package dsst_pkg;

    localparam int COUNT_BITS_DEF  = 16;
    localparam int HEIGHT_BITS_DEF = 31;
    localparam int REM_STEP_BITS   = 4;

    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int VER_W        = 32;
    localparam int TIME_W       = 63;
    localparam int PERIOD_W     = 16;
    localparam int CFG_H_W      = 31;
    localparam int BIT_SEL_W    = 5;
    localparam int STATE_CODE_W = 3;

    localparam logic [2:0] VER_TOP_PATTERN = 3'b001;

    localparam logic signed [CFG_W-1:0] START_ALWAYS = -64'sd1;
    localparam logic signed [CFG_W-1:0] START_NEVER  = -64'sd2;

    localparam logic [CFG_W-1:0]    START_TIME_RST = 64'hFFFF_FFFF_FFFF_FFFE;
    localparam logic [TIME_W-1:0]   TIMEOUT_RST    = {TIME_W{1'b1}};
    localparam logic [PERIOD_W-1:0] PERIOD_RST     = 16'd2016;
    localparam logic [PERIOD_W-1:0] THRESH_RST     = 16'd1916;
    localparam logic [CFG_H_W-1:0]  H_ALL_ONES     = {CFG_H_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_TIME    = 3'd0,
        CFG_TIMEOUT_TIME  = 3'd1,
        CFG_PERIOD_LENGTH = 3'd2,
        CFG_THRESHOLD     = 3'd3,
        CFG_MIN_ACT       = 3'd4,
        CFG_MAX_ACT       = 3'd5,
        CFG_ACT_DURATION  = 3'd6,
        CFG_SIGNAL_BIT    = 3'd7
    } t_cfg_idx;

    typedef enum logic [5:0] {
        ST_DEFINED = 6'b000001,
        ST_STARTED = 6'b000010,
        ST_LOCKED  = 6'b000100,
        ST_ACTIVE  = 6'b001000,
        ST_FAILED  = 6'b010000,
        ST_EXPIRED = 6'b100000
    } t_state;

    localparam logic [STATE_CODE_W-1:0] CODE_DEFINED = 3'd0;
    localparam logic [STATE_CODE_W-1:0] CODE_STARTED = 3'd1;
    localparam logic [STATE_CODE_W-1:0] CODE_LOCKED  = 3'd2;
    localparam logic [STATE_CODE_W-1:0] CODE_ACTIVE  = 3'd3;
    localparam logic [STATE_CODE_W-1:0] CODE_FAILED  = 3'd4;
    localparam logic [STATE_CODE_W-1:0] CODE_EXPIRED = 3'd5;

    function automatic logic [STATE_CODE_W-1:0] state_code(input t_state st);
        logic [STATE_CODE_W-1:0] code;
        case (st)
            ST_DEFINED: code = CODE_DEFINED;
            ST_STARTED: code = CODE_STARTED;
            ST_LOCKED:  code = CODE_LOCKED;
            ST_ACTIVE:  code = CODE_ACTIVE;
            ST_FAILED:  code = CODE_FAILED;
            ST_EXPIRED: code = CODE_EXPIRED;
            default:    code = CODE_DEFINED;
        endcase
        return code;
    endfunction

endpackage

// ===== design/dsst_rem_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsst_rem_pipe
// Pipelined remainder unit: STEP_BITS restoring steps per stage, side data
// carried along, per-stage valid with bubble collapsing.
// ----------------------------------------------------------------------------
module dsst_rem_pipe #(
    parameter int DIVIDEND_W = dsst_pkg::HEIGHT_BITS_DEF,
    parameter int DIVISOR_W  = dsst_pkg::PERIOD_W,
    parameter int SIDE_W     = dsst_pkg::TIME_W + 1,
    parameter int STEP_BITS  = dsst_pkg::REM_STEP_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [DIVIDEND_W-1:0] i_num,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [DIVIDEND_W-1:0] o_num,
    output logic [DIVISOR_W-1:0]  o_rem,
    output logic [SIDE_W-1:0]     o_side
);

    localparam int STAGES = (DIVIDEND_W + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W  = STAGES * STEP_BITS;

    logic [STAGES-1:0]     s_vld;
    logic [DIVISOR_W-1:0]  s_rem  [STAGES];
    logic [DIVIDEND_W-1:0] s_num  [STAGES];
    logic [SIDE_W-1:0]     s_side [STAGES];
    logic [STAGES:0]       en;

    always_comb begin
        en[STAGES] = !i_out_stall;
        for (int k = STAGES - 1; k >= 0; k--) begin
            en[k] = !s_vld[k] || en[k+1];
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic                  vld_in;
        logic [DIVISOR_W-1:0]  rem_in;
        logic [DIVIDEND_W-1:0] num_in;
        logic [SIDE_W-1:0]     side_in;
        logic [DIVISOR_W-1:0]  n_rem;
        logic [PAD_W-1:0]      num_pad;
        logic [DIVISOR_W:0]    trial;
        logic                  r_vld;
        logic [DIVISOR_W-1:0]  r_rem;
        logic [DIVIDEND_W-1:0] r_num;
        logic [SIDE_W-1:0]     r_side;

        if (g == 0) begin : g_first
            assign vld_in  = i_in_valid;
            assign rem_in  = '0;
            assign num_in  = i_num;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = s_vld[g-1];
            assign rem_in  = s_rem[g-1];
            assign num_in  = s_num[g-1];
            assign side_in = s_side[g-1];
        end

        always_comb begin
            num_pad = PAD_W'(num_in);
            n_rem   = rem_in;
            trial   = '0;
            for (int j = 0; j < STEP_BITS; j++) begin
                trial = {n_rem, num_pad[PAD_W - 1 - g * STEP_BITS - j]};
                if (trial >= {1'b0, i_divisor}) begin
                    trial = trial - {1'b0, i_divisor};
                end
                n_rem = trial[DIVISOR_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (en[g]) begin
                r_vld <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[g]) begin
                r_rem  <= n_rem;
                r_num  <= num_in;
                r_side <= side_in;
            end
        end

        assign s_vld[g]  = r_vld;
        assign s_rem[g]  = r_rem;
        assign s_num[g]  = r_num;
        assign s_side[g] = r_side;
    end

    assign o_in_stall  = !en[0];
    assign o_out_valid = s_vld[STAGES-1];
    assign o_rem       = s_rem[STAGES-1];
    assign o_num       = s_num[STAGES-1];
    assign o_side      = s_side[STAGES-1];

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (i_divisor != '0) |-> o_rem < i_divisor)
        else $error("remainder not below divisor");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> s_vld[0])
        else $error("input stalled with empty first stage");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("pipeline holds an item after reset");

endmodule

// ===== design/deployment_signal_state_tracker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deployment_signal_state_tracker_core
// Version-bits deployment state tracker: per-period signal counting and
// state transitions at period ends, one block per item.
//
// Structure: the pipelined height-modulo-period unit followed by the
//   state/result stage.
// Throughput: one item per cycle; stalls only when the output is held.
// Reset: synchronous, clears pipeline, state and counters; restores the
//   configuration registers to their documented defaults.
// ----------------------------------------------------------------------------
module deployment_signal_state_tracker_core #(
    parameter int COUNT_BITS  = dsst_pkg::COUNT_BITS_DEF,
    parameter int HEIGHT_BITS = dsst_pkg::HEIGHT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dsst_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dsst_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [dsst_pkg::VER_W-1:0]        i_block_version,
    input  logic [dsst_pkg::TIME_W-1:0]       i_median_time,
    input  logic [HEIGHT_BITS-1:0]            i_block_height,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [dsst_pkg::STATE_CODE_W-1:0] o_next_state,
    output logic [HEIGHT_BITS-1:0]            o_state_since_height,
    output logic [COUNT_BITS-1:0]             o_period_signal_count,
    output logic [dsst_pkg::PERIOD_W-1:0]     o_period_elapsed,
    output logic                              o_still_possible,
    output logic                              o_version_signal
);
    import dsst_pkg::*;

    localparam int SIDE_W = TIME_W + 1;
    localparam int WIDE_W = 34;

    // configuration
    logic signed [CFG_W-1:0] r_start_time;
    logic [TIME_W-1:0]       r_timeout;
    logic [PERIOD_W-1:0]     r_period;
    logic [PERIOD_W-1:0]     r_threshold;
    logic [CFG_H_W-1:0]      r_min_act;
    logic [CFG_H_W-1:0]      r_max_act;
    logic [CFG_H_W-1:0]      r_duration;
    logic [BIT_SEL_W-1:0]    r_signal_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_time <= START_TIME_RST;
            r_timeout    <= TIMEOUT_RST;
            r_period     <= PERIOD_RST;
            r_threshold  <= THRESH_RST;
            r_min_act    <= '0;
            r_max_act    <= H_ALL_ONES;
            r_duration   <= H_ALL_ONES;
            r_signal_bit <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_START_TIME:    r_start_time <= i_cfg_data;
                CFG_TIMEOUT_TIME:  r_timeout    <= i_cfg_data[TIME_W-1:0];
                CFG_PERIOD_LENGTH: r_period     <= i_cfg_data[PERIOD_W-1:0];
                CFG_THRESHOLD:     r_threshold  <= i_cfg_data[PERIOD_W-1:0];
                CFG_MIN_ACT:       r_min_act    <= i_cfg_data[CFG_H_W-1:0];
                CFG_MAX_ACT:       r_max_act    <= i_cfg_data[CFG_H_W-1:0];
                CFG_ACT_DURATION:  r_duration   <= i_cfg_data[CFG_H_W-1:0];
                CFG_SIGNAL_BIT:    r_signal_bit <= i_cfg_data[BIT_SEL_W-1:0];
                default: ;
            endcase
        end
    end

    logic [PERIOD_W-1:0] period_eff;
    logic                in_sig;
    logic                fixed_mode;

    assign period_eff = (r_period == '0) ? PERIOD_W'(1) : r_period;
    assign in_sig     = (i_block_version[VER_W-1 -: 3] == VER_TOP_PATTERN)
                        && i_block_version[r_signal_bit];
    assign fixed_mode = (r_start_time == START_ALWAYS) || (r_start_time == START_NEVER);

    // height modulo period
    logic                   p_valid;
    logic                   p_stall;
    logic [HEIGHT_BITS-1:0] p_height;
    logic [PERIOD_W-1:0]    p_pos;
    logic [SIDE_W-1:0]      p_side;

    dsst_rem_pipe #(
        .DIVIDEND_W (HEIGHT_BITS),
        .DIVISOR_W  (PERIOD_W),
        .SIDE_W     (SIDE_W),
        .STEP_BITS  (REM_STEP_BITS)
    ) u_rem_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_divisor   (period_eff),
        .i_in_valid  (i_valid),
        .o_in_stall  (o_stall),
        .i_num       (i_block_height),
        .i_side      ({in_sig, i_median_time}),
        .o_out_valid (p_valid),
        .i_out_stall (p_stall),
        .o_num       (p_height),
        .o_rem       (p_pos),
        .o_side      (p_side)
    );

    // tracker state
    t_state                 r_state;
    logic [HEIGHT_BITS-1:0] r_since;
    logic [COUNT_BITS-1:0]  r_count;
    logic [HEIGHT_BITS-1:0] r_ash;
    logic                   r_out_valid;

    t_state                 n_state;
    t_state                 tgt;
    logic [HEIGHT_BITS-1:0] n_since;
    logic [COUNT_BITS-1:0]  n_count;
    logic [COUNT_BITS-1:0]  count_base;
    logic [HEIGHT_BITS-1:0] n_ash;
    logic                   cap;
    logic                   b_sig;
    logic [TIME_W-1:0]      b_mtp;
    logic [PERIOD_W-1:0]    elapsed;
    logic                   period_end;
    logic [HEIGHT_BITS-1:0] nh;
    logic                   before_start;
    logic                   thresh_met;
    logic                   forced_lock;
    logic                   timed_out;
    logic                   min_reached;
    logic                   expired;
    logic [32:0]            max_minus_p;
    logic [32:0]            expire_at;
    logic [WIDE_W-1:0]      sp_lhs;
    logic [WIDE_W-1:0]      sp_rhs;
    logic [STATE_CODE_W-1:0] n_code;
    logic [HEIGHT_BITS-1:0]  n_out_since;

    assign cap     = p_valid && !p_stall;
    assign p_stall = r_out_valid && i_stall;
    assign b_sig   = p_side[SIDE_W-1];
    assign b_mtp   = p_side[TIME_W-1:0];

    always_comb begin
        elapsed    = p_pos + PERIOD_W'(1);
        period_end = (elapsed == period_eff);
        nh         = (p_height == '1) ? p_height : p_height + HEIGHT_BITS'(1);

        count_base = (p_pos == '0) ? '0 : r_count;
        n_count    = (b_sig && (count_base != '1)) ? count_base + COUNT_BITS'(1)
                                                   : count_base;

        before_start = $signed({1'b0, b_mtp}) < r_start_time;
        thresh_met   = WIDE_W'(n_count) >= WIDE_W'(r_threshold);
        max_minus_p  = 33'(r_max_act) - 33'(period_eff);
        forced_lock  = (r_max_act != H_ALL_ONES)
                       && ($signed(33'(nh)) >= $signed(max_minus_p));
        timed_out    = b_mtp >= r_timeout;
        min_reached  = 32'(nh) >= 32'(r_min_act);
        expire_at    = 33'(r_ash) + 33'(r_duration);
        expired      = (r_duration != H_ALL_ONES) && (33'(nh) >= expire_at);

        tgt   = r_state;
        n_ash = r_ash;
        if (!fixed_mode && period_end) begin
            if (before_start) begin
                tgt = ST_DEFINED;
            end else begin
                case (r_state)
                    ST_DEFINED: tgt = ST_STARTED;
                    ST_STARTED: begin
                        if (thresh_met || forced_lock) begin
                            tgt = ST_LOCKED;
                        end else if (timed_out) begin
                            tgt = ST_FAILED;
                        end
                    end
                    ST_LOCKED: begin
                        if (min_reached) begin
                            tgt   = ST_ACTIVE;
                            n_ash = nh;
                        end
                    end
                    ST_ACTIVE: begin
                        if (expired) begin
                            tgt = ST_EXPIRED;
                        end
                    end
                    default: ;
                endcase
            end
        end

        n_state = r_state;
        n_since = r_since;
        if (tgt != r_state) begin
            n_state = tgt;
            n_since = (tgt == ST_DEFINED) ? '0 : nh;
        end

        if (r_start_time == START_ALWAYS) begin
            n_code      = CODE_ACTIVE;
            n_out_since = '0;
        end else if (r_start_time == START_NEVER) begin
            n_code      = CODE_FAILED;
            n_out_since = '0;
        end else begin
            n_code      = state_code(n_state);
            n_out_since = (n_state == ST_DEFINED) ? '0 : n_since;
        end

        sp_lhs = WIDE_W'(period_eff) - WIDE_W'(r_threshold);
        sp_rhs = WIDE_W'(elapsed) - WIDE_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_DEFINED;
            r_since     <= '0;
            r_count     <= '0;
            r_ash       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cap) begin
                r_state     <= n_state;
                r_since     <= n_since;
                r_count     <= n_count;
                r_ash       <= n_ash;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cap) begin
            o_next_state          <= n_code;
            o_state_since_height  <= n_out_since;
            o_period_signal_count <= n_count;
            o_period_elapsed      <= elapsed;
            o_still_possible      <= $signed(sp_lhs) >= $signed(sp_rhs);
            o_version_signal      <= !fixed_mode
                                     && ((n_code == CODE_STARTED) || (n_code == CODE_LOCKED));
        end
    end

    assign o_valid = r_out_valid;

    a_version_signal_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_version_signal |->
            (o_next_state == CODE_STARTED) || (o_next_state == CODE_LOCKED))
        else $error("version signal outside started or locked state");

    a_defined_since_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_next_state == CODE_DEFINED) |-> (o_state_since_height == '0))
        else $error("defined state with nonzero since height");

    a_elapsed_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_period_elapsed != '0))
        else $error("period elapsed is zero");

    a_state_holds_without_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cap |=> $stable(r_state) && $stable(r_count))
        else $error("tracker state changed without an item");

endmodule
